/* sv/prt_pkg.sv */
package prt_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OP_WIDTH = 2;
    localparam int INDEX_WIDTH = 5;
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int PRESCALE_WIDTH_DEF = 16;

    localparam logic [OP_WIDTH-1:0] OP_TICK = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_READ = 2'd2;

    localparam logic [INDEX_WIDTH-1:0] REG_CONTROL = 5'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_IRQ_ENABLE = 5'd3;
    localparam logic [INDEX_WIDTH-1:0] REG_STATUS = 5'd4;
    localparam logic [INDEX_WIDTH-1:0] REG_EVENT = 5'd5;
    localparam logic [INDEX_WIDTH-1:0] REG_COUNTER = 5'd9;
    localparam logic [INDEX_WIDTH-1:0] REG_PRESCALER = 5'd10;
    localparam logic [INDEX_WIDTH-1:0] REG_RELOAD = 5'd11;

    typedef struct packed {
        logic [OP_WIDTH-1:0]    operation;
        logic [INDEX_WIDTH-1:0] reg_index;
        logic [DATA_WIDTH-1:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq;
        logic                  update_event;
    } rsp_t;

endpackage

/* sv/prt_if.sv */
interface prt_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [prt_pkg::OP_WIDTH-1:0]          operation;
    logic [prt_pkg::INDEX_WIDTH-1:0]       reg_index;
    logic [prt_pkg::DATA_WIDTH-1:0]        write_data;

    modport source (output valid, output operation, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input operation, input reg_index, input write_data,
                  output ready);
endinterface

interface prt_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [prt_pkg::DATA_WIDTH-1:0]        read_data;
    logic                                  irq;
    logic                                  update_event;

    modport source (output valid, output read_data, output irq, output update_event,
                    input ready);
    modport sink (input valid, input read_data, input irq, input update_event,
                  output ready);
endinterface

/* sv/prt_core.sv */
module prt_core #(
    parameter int COUNTER_WIDTH = prt_pkg::COUNTER_WIDTH_DEF,
    parameter int PRESCALE_WIDTH = prt_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  prt_pkg::req_t      req,
    output prt_pkg::rsp_t      rsp
);

    logic                      enable_reg, enable_next;
    logic                      irq_enable_reg, irq_enable_next;
    logic                      flag_reg, flag_next;
    logic [PRESCALE_WIDTH-1:0] psc_buf_reg, psc_buf_next;
    logic [PRESCALE_WIDTH-1:0] psc_act_reg, psc_act_next;
    logic [PRESCALE_WIDTH-1:0] psc_cnt_reg, psc_cnt_next;
    logic [COUNTER_WIDTH-1:0]  reload_reg, reload_next;
    logic [COUNTER_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                      event_flag;
    logic [prt_pkg::DATA_WIDTH-1:0] rdata;

    always_comb
    begin
        enable_next = enable_reg;
        irq_enable_next = irq_enable_reg;
        flag_next = flag_reg;
        psc_buf_next = psc_buf_reg;
        psc_act_next = psc_act_reg;
        psc_cnt_next = psc_cnt_reg;
        reload_next = reload_reg;
        cnt_next = cnt_reg;
        event_flag = 1'b0;
        rdata = '0;
        case (req.operation)
            prt_pkg::OP_TICK:
            begin
                if (enable_reg)
                begin
                    if (psc_cnt_reg >= psc_act_reg)
                    begin
                        psc_cnt_next = '0;
                        if (reload_reg != '0)
                        begin
                            if (cnt_reg == reload_reg)
                            begin
                                cnt_next = '0;
                                psc_act_next = psc_buf_reg;
                                flag_next = 1'b1;
                                event_flag = 1'b1;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        psc_cnt_next = psc_cnt_reg + 1'b1;
                    end
                end
            end
            prt_pkg::OP_WRITE:
            begin
                unique case (req.reg_index)
                    prt_pkg::REG_CONTROL: enable_next = req.write_data[0];
                    prt_pkg::REG_IRQ_ENABLE: irq_enable_next = req.write_data[0];
                    prt_pkg::REG_STATUS:
                    begin
                        if (!req.write_data[0])
                        begin
                            flag_next = 1'b0;
                        end
                    end
                    prt_pkg::REG_EVENT:
                    begin
                        if (req.write_data[0])
                        begin
                            cnt_next = '0;
                            psc_cnt_next = '0;
                            psc_act_next = psc_buf_reg;
                            flag_next = 1'b1;
                            event_flag = 1'b1;
                        end
                    end
                    prt_pkg::REG_COUNTER: cnt_next = req.write_data[COUNTER_WIDTH-1:0];
                    prt_pkg::REG_PRESCALER: psc_buf_next = req.write_data[PRESCALE_WIDTH-1:0];
                    prt_pkg::REG_RELOAD: reload_next = req.write_data[COUNTER_WIDTH-1:0];
                    default: ;
                endcase
            end
            prt_pkg::OP_READ:
            begin
                unique case (req.reg_index)
                    prt_pkg::REG_CONTROL: rdata = prt_pkg::DATA_WIDTH'(enable_reg);
                    prt_pkg::REG_IRQ_ENABLE: rdata = prt_pkg::DATA_WIDTH'(irq_enable_reg);
                    prt_pkg::REG_STATUS: rdata = prt_pkg::DATA_WIDTH'(flag_reg);
                    prt_pkg::REG_COUNTER: rdata = prt_pkg::DATA_WIDTH'(cnt_reg);
                    prt_pkg::REG_PRESCALER: rdata = prt_pkg::DATA_WIDTH'(psc_buf_reg);
                    prt_pkg::REG_RELOAD: rdata = prt_pkg::DATA_WIDTH'(reload_reg);
                    default: rdata = '0;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rsp.read_data = rdata;
        rsp.irq = flag_next & irq_enable_next;
        rsp.update_event = event_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            irq_enable_reg <= 1'b0;
            flag_reg <= 1'b0;
            psc_buf_reg <= '0;
            psc_act_reg <= '0;
            psc_cnt_reg <= '0;
            reload_reg <= '1;
            cnt_reg <= '0;
        end
        else if (fire)
        begin
            enable_reg <= enable_next;
            irq_enable_reg <= irq_enable_next;
            flag_reg <= flag_next;
            psc_buf_reg <= psc_buf_next;
            psc_act_reg <= psc_act_next;
            psc_cnt_reg <= psc_cnt_next;
            reload_reg <= reload_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* sv/prescaled_reload_timer_regs.sv */
// channel  dir  payload                              transfer
// req      in   operation, reg_index, write_data     valid & ready
// rsp      out  read_data, irq, update_event         valid & ready
//
// one result per request; request enters the input register, result the result register
// one request per cycle if rsp is ready: input register, single-pass core, result register
// rst_n clears the timer registers (reload to all ones) and both stage valids
// a stalled rsp holds the result; req keeps flowing until both stages are full
module prescaled_reload_timer_regs #(
    parameter int COUNTER_WIDTH = prt_pkg::COUNTER_WIDTH_DEF,
    parameter int PRESCALE_WIDTH = prt_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    prt_req_if.sink      req,
    prt_rsp_if.source    rsp
);

    logic          in_valid_reg;
    prt_pkg::req_t in_data_reg;
    logic          out_valid_reg;
    prt_pkg::rsp_t out_data_reg;
    prt_pkg::rsp_t core_rsp;
    logic          advance;

    assign advance = in_valid_reg & (~out_valid_reg | rsp.ready);
    assign req.ready = ~in_valid_reg | advance;

    prt_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .PRESCALE_WIDTH(PRESCALE_WIDTH)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (advance),
        .req  (in_data_reg),
        .rsp  (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg.operation <= req.operation;
            in_data_reg.reg_index <= req.reg_index;
            in_data_reg.write_data <= req.write_data;
        end
        if (advance)
        begin
            out_data_reg <= core_rsp;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.read_data = out_data_reg.read_data;
    assign rsp.irq = out_data_reg.irq;
    assign rsp.update_event = out_data_reg.update_event;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import prt_pkg::*;

    localparam int CW = COUNTER_WIDTH_DEF;
    localparam int PW = PRESCALE_WIDTH_DEF;
    localparam logic [OP_WIDTH-1:0] OP_IDLE = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct {
        req_t        req;
        bit          drain_first;
        int unsigned idle_pct;
        int unsigned stall_pct;
    } pending_t;

    logic clk;
    logic rst_n;

    prt_req_if req_ch ();
    prt_rsp_if rsp_ch ();

    prescaled_reload_timer_regs dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // timer state as the block should hold it
    bit          tmr_enable;
    bit          tmr_irq_enable;
    bit          tmr_update_flag;
    logic [PW-1:0] psc_buffer;
    logic [PW-1:0] psc_active;
    logic [PW-1:0] psc_count;
    logic [CW-1:0] reload_val;
    logic [CW-1:0] main_cnt;

    pending_t    pending_q[$];
    rsp_t        results_due[$];
    int          sent_count;
    int          queued_count;
    int          fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cur_idle;
    int unsigned cur_stall;
    bit          drain_next;

    function automatic rsp_t timer_step(input req_t r);
        rsp_t res;
        res = '0;
        case (r.operation)
            OP_TICK:
            begin
                if (tmr_enable)
                begin
                    if (psc_count >= psc_active)
                    begin
                        psc_count = '0;
                        if (reload_val != '0)
                        begin
                            if (main_cnt == reload_val)
                            begin
                                main_cnt = '0;
                                psc_active = psc_buffer;
                                tmr_update_flag = 1'b1;
                                res.update_event = 1'b1;
                            end
                            else
                            begin
                                main_cnt = main_cnt + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        psc_count = psc_count + 1'b1;
                    end
                end
            end
            OP_WRITE:
            begin
                case (r.reg_index)
                    REG_CONTROL:    tmr_enable = r.write_data[0];
                    REG_IRQ_ENABLE: tmr_irq_enable = r.write_data[0];
                    REG_STATUS:     if (!r.write_data[0]) tmr_update_flag = 1'b0;
                    REG_EVENT:
                    begin
                        if (r.write_data[0])
                        begin
                            main_cnt = '0;
                            psc_count = '0;
                            psc_active = psc_buffer;
                            tmr_update_flag = 1'b1;
                            res.update_event = 1'b1;
                        end
                    end
                    REG_COUNTER:    main_cnt = r.write_data[CW-1:0];
                    REG_PRESCALER:  psc_buffer = r.write_data[PW-1:0];
                    REG_RELOAD:     reload_val = r.write_data[CW-1:0];
                    default: ;
                endcase
            end
            OP_READ:
            begin
                case (r.reg_index)
                    REG_CONTROL:    res.read_data = DATA_WIDTH'(tmr_enable);
                    REG_IRQ_ENABLE: res.read_data = DATA_WIDTH'(tmr_irq_enable);
                    REG_STATUS:     res.read_data = DATA_WIDTH'(tmr_update_flag);
                    REG_COUNTER:    res.read_data = DATA_WIDTH'(main_cnt);
                    REG_PRESCALER:  res.read_data = DATA_WIDTH'(psc_buffer);
                    REG_RELOAD:     res.read_data = DATA_WIDTH'(reload_val);
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.irq = tmr_update_flag & tmr_irq_enable;
        return res;
    endfunction

    task automatic add_item(input logic [OP_WIDTH-1:0] op, input logic [INDEX_WIDTH-1:0] idx,
                            input logic [DATA_WIDTH-1:0] data);
        pending_t p;
        p.req.operation = op;
        p.req.reg_index = idx;
        p.req.write_data = data;
        p.drain_first = drain_next;
        p.idle_pct = cur_idle;
        p.stall_pct = cur_stall;
        drain_next = 1'b0;
        pending_q.push_back(p);
        queued_count++;
    endtask

    function automatic logic [INDEX_WIDTH-1:0] pick_index();
        logic [INDEX_WIDTH-1:0] mapped [7];
        mapped = '{REG_CONTROL, REG_IRQ_ENABLE, REG_STATUS, REG_EVENT,
                   REG_COUNTER, REG_PRESCALER, REG_RELOAD};
        if ($urandom_range(1))
            return mapped[$urandom_range(6)];
        return INDEX_WIDTH'($urandom_range(31));
    endfunction

    // setup writes followed by a burst of ticks with register traffic mixed in
    task automatic add_counting_run();
        int unsigned pick;
        int unsigned steps;
        logic [CW-1:0] rl;
        pick = $urandom_range(99);
        if (pick < 8)
            rl = '0;
        else if (pick < 14)
            rl = CW'($urandom);
        else
            rl = CW'($urandom_range(1, 12));
        add_item(OP_WRITE, REG_RELOAD, rl);
        pick = $urandom_range(99);
        if (pick < 5)
            add_item(OP_WRITE, REG_PRESCALER, $urandom);
        else
            add_item(OP_WRITE, REG_PRESCALER,
                     {16'($urandom_range(16'hFFFF)), 16'($urandom_range(3))});
        if ($urandom_range(1))
            add_item(OP_WRITE, REG_EVENT, {31'($urandom), 1'b1});
        pick = $urandom_range(99);
        if (pick < 20)
            add_item(OP_WRITE, REG_COUNTER, {CW{1'b1}} - CW'($urandom_range(6)));
        else if (pick < 40)
            add_item(OP_WRITE, REG_COUNTER, CW'($urandom_range(12)));
        add_item(OP_WRITE, REG_IRQ_ENABLE, $urandom);
        add_item(OP_WRITE, REG_CONTROL, {31'($urandom), ($urandom_range(9) != 0)});
        steps = $urandom_range(8, 40);
        repeat (steps)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_item(OP_TICK, INDEX_WIDTH'($urandom_range(31)), $urandom);
            else if (pick < 80)
                add_item(OP_READ, pick_index(), $urandom);
            else if (pick < 85)
                add_item(OP_WRITE, REG_STATUS, $urandom);
            else if (pick < 88)
                add_item(OP_WRITE, REG_EVENT, $urandom);
            else if (pick < 91)
                add_item(OP_WRITE, REG_CONTROL, $urandom);
            else if (pick < 94)
                add_item(OP_IDLE, INDEX_WIDTH'($urandom_range(31)), $urandom);
            else
                add_item(OP_WIDTH'($urandom_range(3)), pick_index(), $urandom);
        end
    endtask

    always @(posedge clk)
    begin : drive_req
        pending_t nxt;
        req_t taken;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.operation = req_ch.operation;
                taken.reg_index = req_ch.reg_index;
                taken.write_data = req_ch.write_data;
                results_due.push_back(timer_step(taken));
                sent_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() != 0
                    && (!pending_q[0].drain_first || results_due.size() == 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    send_idle_pct = nxt.idle_pct;
                    recv_stall_pct = nxt.stall_pct;
                    req_ch.valid <= 1'b1;
                    req_ch.operation <= nxt.req.operation;
                    req_ch.reg_index <= nxt.req.reg_index;
                    req_ch.write_data <= nxt.req.write_data;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watch_rsp
        rsp_t exp_r;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %h/%b/%b", $time,
                             rsp_ch.read_data, rsp_ch.irq, rsp_ch.update_event);
                    fail_count++;
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    if (rsp_ch.read_data !== exp_r.read_data)
                    begin
                        $display("%0t: read_data mismatch, expected %h, actual %h", $time,
                                 exp_r.read_data, rsp_ch.read_data);
                        fail_count++;
                    end
                    if (rsp_ch.irq !== exp_r.irq)
                    begin
                        $display("%0t: irq mismatch, expected %b, actual %b", $time,
                                 exp_r.irq, rsp_ch.irq);
                        fail_count++;
                    end
                    if (rsp_ch.update_event !== exp_r.update_event)
                    begin
                        $display("%0t: update_event mismatch, expected %b, actual %b", $time,
                                 exp_r.update_event, rsp_ch.update_event);
                        fail_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_TICK;
        req_ch.reg_index = '0;
        req_ch.write_data = '0;
        rsp_ch.ready = 1'b0;
        tmr_enable = 1'b0;
        tmr_irq_enable = 1'b0;
        tmr_update_flag = 1'b0;
        psc_buffer = '0;
        psc_active = '0;
        psc_count = '0;
        reload_val = '1;
        main_cnt = '0;
        sent_count = 0;
        queued_count = 0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_idle = 0;
        cur_stall = 0;
        drain_next = 1'b0;

        // reset values, masking, unmapped offsets, no-op code
        add_item(OP_READ, REG_RELOAD, '0);
        add_item(OP_READ, REG_COUNTER, '0);
        add_item(OP_TICK, '0, '0);
        add_item(OP_WRITE, REG_PRESCALER, '1);
        add_item(OP_READ, REG_PRESCALER, '1);
        add_item(OP_IDLE, '1, '1);
        add_item(OP_WRITE, '1, '1);
        add_item(OP_READ, '1, '1);
        add_item(OP_READ, REG_EVENT, '0);
        add_item(OP_WRITE, REG_EVENT, 32'hFFFF_FFFE);
        add_item(OP_READ, REG_STATUS, '0);
        // forced update and flag handling
        add_item(OP_WRITE, REG_PRESCALER, 32'd1);
        add_item(OP_WRITE, REG_EVENT, 32'd1);
        add_item(OP_WRITE, REG_IRQ_ENABLE, '1);
        add_item(OP_WRITE, REG_STATUS, '1);
        add_item(OP_WRITE, REG_STATUS, 32'hFFFF_FFFE);
        // zero reload holds the counter
        add_item(OP_WRITE, REG_RELOAD, '0);
        add_item(OP_WRITE, REG_CONTROL, 32'd1);
        repeat (3) add_item(OP_TICK, '0, '0);
        // counter above reload rolls over silently
        add_item(OP_WRITE, REG_RELOAD, 32'd2);
        add_item(OP_WRITE, REG_COUNTER, '1);
        repeat (2) add_item(OP_TICK, '1, '1);
        add_item(OP_READ, REG_COUNTER, '0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    cur_idle = 0;
                    cur_stall = 0;
                end
                1:
                begin
                    cur_idle = 56;
                    cur_stall = 0;
                end
                2:
                begin
                    cur_idle = 0;
                    cur_stall = 56;
                end
                default:
                begin
                    cur_idle = 13;
                    cur_stall = 13;
                end
            endcase
            if (ph == 3 || ph == 6)
                drain_next = 1'b1;
            queued_count = 0;
            while (queued_count < ITEMS_PER_PHASE)
                add_counting_run();
        end
        queued_count = sent_count + pending_q.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (sent_count < queued_count || results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
